// File: hdl/lnq_pkg.sv
// Shared types and constants for the quantized two-neuron linear layer.
// No dependencies; every other file in this folder refers to it by scoped names.
package lnq_pkg;

   localparam int LANES_DEF   = 4;   // default lane count
   localparam int ACT_W       = 8;   // one activation
   localparam int WGT_W       = 2;   // one packed signed weight
   localparam int PROD_W      = 10;  // activation * weight, signed
   localparam int SUM_W       = 32;  // accumulator and requantizer datapath
   localparam int NIB_W       = 4;   // one quantized neuron
   localparam int FIELD_LANES = 4;   // lanes that the activation and weight fields can fill
   localparam int SHIFT_W     = 5;
   localparam int MULT_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 176;
   localparam int RSP_DATA_W  = 8;
   localparam logic [SUM_W-1:0] CLIP_MAX = SUM_W'(15);

   typedef enum logic [1:0] {
      CSR_SHIFT = 2'd0,
      CSR_MULT  = 2'd1,
      CSR_RELU  = 2'd2,
      CSR_BNORM = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      QM_PLAIN = 2'd0,
      QM_RELU  = 2'd1,
      QM_BNORM = 2'd2
   } qmode_type;

   typedef struct packed {
      logic                 load;
      qmode_type            mode;
      logic [SHIFT_W-1:0]   shift;
   } qctl_type;

endpackage

// File: hdl/lnq_lane.sv
// One multiply lane: activation times signed 2-bit weight for both neurons.
// Depends on lnq_pkg.
module lnq_lane (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [lnq_pkg::ACT_W-1:0]              act,
   input  logic [lnq_pkg::WGT_W-1:0]              wgt_a,
   input  logic [lnq_pkg::WGT_W-1:0]              wgt_b,
   output logic signed [lnq_pkg::PROD_W-1:0]      prod_a_ff,
   output logic signed [lnq_pkg::PROD_W-1:0]      prod_b_ff
);

   logic signed [lnq_pkg::PROD_W-1:0] act_ext;
   logic signed [lnq_pkg::PROD_W-1:0] wgt_a_ext;
   logic signed [lnq_pkg::PROD_W-1:0] wgt_b_ext;
   logic signed [lnq_pkg::PROD_W-1:0] prod_a_in;
   logic signed [lnq_pkg::PROD_W-1:0] prod_b_in;

   // zero-extend the activation, sign-extend the weights
   assign act_ext   = $signed({{(lnq_pkg::PROD_W-lnq_pkg::ACT_W){1'b0}}, act});
   assign wgt_a_ext = $signed({{(lnq_pkg::PROD_W-lnq_pkg::WGT_W){wgt_a[lnq_pkg::WGT_W-1]}}, wgt_a});
   assign wgt_b_ext = $signed({{(lnq_pkg::PROD_W-lnq_pkg::WGT_W){wgt_b[lnq_pkg::WGT_W-1]}}, wgt_b});
   assign prod_a_in = act_ext * wgt_a_ext;
   assign prod_b_in = act_ext * wgt_b_ext;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

endmodule

// File: hdl/lnq_merge.sv
// Merge stage: sums the lane products and keeps the two wrapping accumulators.
// Depends on lnq_pkg; fed by the lnq_lane instances.
module lnq_merge #(
   parameter int LANES = lnq_pkg::LANES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic                                last,
   input  logic signed [lnq_pkg::PROD_W-1:0]   prod_a [LANES],
   input  logic signed [lnq_pkg::PROD_W-1:0]   prod_b [LANES],
   output logic [lnq_pkg::SUM_W-1:0]           total_a,
   output logic [lnq_pkg::SUM_W-1:0]           total_b
);

   localparam int GRP_W = lnq_pkg::PROD_W + $clog2(LANES);

   logic signed [GRP_W-1:0]    grp_a;
   logic signed [GRP_W-1:0]    grp_b;
   logic [lnq_pkg::SUM_W-1:0]  acc_a_ff, acc_a_in;
   logic [lnq_pkg::SUM_W-1:0]  acc_b_ff, acc_b_in;

   always_comb begin
      grp_a = '0;
      grp_b = '0;
      for (int i = 0; i < LANES; i++) begin
         grp_a = grp_a + GRP_W'(prod_a[i]);
         grp_b = grp_b + GRP_W'(prod_b[i]);
      end
   end

   // sign-extend the group sum and add; wraps at 32 bits
   assign total_a = acc_a_ff + lnq_pkg::SUM_W'(grp_a);
   assign total_b = acc_b_ff + lnq_pkg::SUM_W'(grp_b);

   // clear after the last group, otherwise advance
   assign acc_a_in = last ? '0 : total_a;
   assign acc_b_in = last ? '0 : total_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (fire) begin
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && last |=> acc_a_ff == '0 && acc_b_ff == '0)
      else $error("accumulators not cleared after last group");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(acc_a_ff) && $stable(acc_b_ff))
      else $error("accumulators moved without a merge");

endmodule

// File: hdl/lnq_quant.sv
// Requantizer for one neuron: multiply, offset add, arithmetic shift, clip to 0..15.
// Depends on lnq_pkg; the multiply is registered, the rest feeds the output register.
module lnq_quant (
   input  logic                          clock,
   input  lnq_pkg::qctl_type             ctl,
   input  logic [lnq_pkg::SUM_W-1:0]     sum,
   input  logic [lnq_pkg::SUM_W-1:0]     scale,
   input  logic [lnq_pkg::SUM_W-1:0]     offset,
   input  logic [lnq_pkg::MULT_W-1:0]    mult,
   output logic [lnq_pkg::NIB_W-1:0]     nibble
);

   logic [lnq_pkg::SUM_W-1:0]        operand;
   logic [lnq_pkg::SUM_W-1:0]        prod_ff, prod_in;
   logic [lnq_pkg::SUM_W-1:0]        addend_ff, addend_in;
   logic [lnq_pkg::SUM_W-1:0]        value;
   logic signed [lnq_pkg::SUM_W-1:0] shifted;

   always_comb begin
      case (ctl.mode)
         lnq_pkg::QM_BNORM: operand = scale;
         lnq_pkg::QM_RELU:  operand = {{(lnq_pkg::SUM_W-lnq_pkg::MULT_W){1'b0}}, mult};
         default:           operand = lnq_pkg::SUM_W'(1);
      endcase
   end

   assign prod_in   = sum * operand;
   assign addend_in = (ctl.mode == lnq_pkg::QM_BNORM) ? offset : '0;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff   <= prod_in;
         addend_ff <= addend_in;
      end
   end

   assign value   = prod_ff + addend_ff;
   assign shifted = $signed(value) >>> ctl.shift;

   always_comb begin
      if (shifted[lnq_pkg::SUM_W-1])
         nibble = '0;
      else if (lnq_pkg::SUM_W'(shifted) > lnq_pkg::CLIP_MAX)
         nibble = lnq_pkg::NIB_W'(lnq_pkg::CLIP_MAX);
      else
         nibble = shifted[lnq_pkg::NIB_W-1:0];
   end

endmodule

// File: hdl/linear_u8_i2_dot_quant_u4.sv
// Top level of the quantized two-neuron linear layer (u8 activations, i2 weights, u4 out).
// Depends on lnq_pkg, lnq_lane, lnq_merge and lnq_quant.
//
// Usage:
//   req_*  : one transaction per group of four activations with their packed weights for
//            neurons A and B; req_tlast marks the final group of the vector, and only on
//            that transaction are the batch-norm scale/offset fields used.
//   rsp_*  : one transaction per vector, neuron A's 4-bit result in bits 3:0, B's in 7:4.
//   csr_*  : register writes (shift, multiplier, relu flag, batch-norm flag); always
//            ready; write only while the block is idle.
// Throughput: one group per cycle while req_tready is high, set by the lane stage and the
//   merge adder, which accumulate a whole group together.
// Result path: the last group passes the lane product registers, the final sums after the
//   merge, the scale multiply register, and offset/shift/clip into the result register.
// Reset: synchronous, clears the accumulators, the stage valid bits and the registers
//   (shift 0, multiplier 1, both flags 0).
// Stall: a valid result register holds while rsp_tready is low; groups that are not last
//   keep flowing into the accumulators, and input stalls only once a last group
//   finds every requantizer stage occupied.
module linear_u8_i2_dot_quant_u4 #(
   parameter int LANES = lnq_pkg::LANES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, lowest bit first: activations[31:0], weights_a[39:32], weights_b[47:40],
   // scale_a[79:48], offset_a[111:80], scale_b[143:112], offset_b[175:144]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lnq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,   // last_group
   // rsp_tdata: packed_result[7:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lnq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  lnq_pkg::csr_index_type             csr_index,
   input  logic [lnq_pkg::CSR_DATA_W-1:0]     csr_data
);

   // request fields
   logic [31:0]                 activations;
   logic [7:0]                  weights_a;
   logic [7:0]                  weights_b;
   logic [lnq_pkg::SUM_W-1:0]   scale_a, offset_a, scale_b, offset_b;

   assign activations = req_tdata[31:0];
   assign weights_a   = req_tdata[39:32];
   assign weights_b   = req_tdata[47:40];
   assign scale_a     = req_tdata[79:48];
   assign offset_a    = req_tdata[111:80];
   assign scale_b     = req_tdata[143:112];
   assign offset_b    = req_tdata[175:144];

   // configuration registers
   logic [lnq_pkg::SHIFT_W-1:0] shift_ff;
   logic [lnq_pkg::MULT_W-1:0]  mult_ff;
   logic                        relu_ff;
   logic                        bnorm_ff;
   logic                        csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         mult_ff  <= lnq_pkg::MULT_W'(1);
         relu_ff  <= 1'b0;
         bnorm_ff <= 1'b0;
      end else if (csr_fire) begin
         case (csr_index)
            lnq_pkg::CSR_SHIFT: shift_ff <= csr_data[lnq_pkg::SHIFT_W-1:0];
            lnq_pkg::CSR_MULT:  mult_ff  <= csr_data;
            lnq_pkg::CSR_RELU:  relu_ff  <= csr_data[0];
            lnq_pkg::CSR_BNORM: bnorm_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // the batch-norm flag alone selects nothing
   lnq_pkg::qmode_type qmode;

   always_comb begin
      if (relu_ff && bnorm_ff)
         qmode = lnq_pkg::QM_BNORM;
      else if (relu_ff)
         qmode = lnq_pkg::QM_RELU;
      else
         qmode = lnq_pkg::QM_PLAIN;
   end

   // pipeline handshake: each stage advances when the next one is empty or moving
   logic p_valid_ff, p_valid_in;
   logic p_last_ff;
   logic q_valid_ff, q_valid_in;
   logic m_valid_ff, m_valid_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic out_take, m_take, q_take, p_take;
   logic req_fire, merge_fire, q_load;

   assign out_take   = !rsp_tvalid_ff || rsp_tready;
   assign m_take     = !m_valid_ff || out_take;
   assign q_take     = !q_valid_ff || m_take;
   // only a last group needs room in the requantizer
   assign p_take     = !p_valid_ff || !p_last_ff || q_take;
   assign req_tready = p_take;
   assign req_fire   = req_tvalid && req_tready;
   assign merge_fire = p_valid_ff && (!p_last_ff || q_take);
   assign q_load     = merge_fire && p_last_ff;

   assign p_valid_in    = p_take ? req_tvalid : p_valid_ff;
   assign q_valid_in    = q_take ? q_load : q_valid_ff;
   assign m_valid_in    = m_take ? q_valid_ff : m_valid_ff;
   assign rsp_tvalid_in = out_take ? m_valid_ff : rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff    <= 1'b0;
         q_valid_ff    <= 1'b0;
         m_valid_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         p_valid_ff    <= p_valid_in;
         q_valid_ff    <= q_valid_in;
         m_valid_ff    <= m_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // lane stage: products plus the fields that travel with the group
   logic [lnq_pkg::SUM_W-1:0] p_scale_a_ff, p_offset_a_ff, p_scale_b_ff, p_offset_b_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_last_ff     <= req_tlast;
         p_scale_a_ff  <= scale_a;
         p_offset_a_ff <= offset_a;
         p_scale_b_ff  <= scale_b;
         p_offset_b_ff <= offset_b;
      end
   end

   logic signed [lnq_pkg::PROD_W-1:0] prod_a [LANES];
   logic signed [lnq_pkg::PROD_W-1:0] prod_b [LANES];

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [lnq_pkg::ACT_W-1:0] act;
      logic [lnq_pkg::WGT_W-1:0] wgt_a;
      logic [lnq_pkg::WGT_W-1:0] wgt_b;

      // lanes past the field width see zero activations and weights
      if (i < lnq_pkg::FIELD_LANES) begin : g_fed
         assign act   = activations[lnq_pkg::ACT_W*i +: lnq_pkg::ACT_W];
         assign wgt_a = weights_a[lnq_pkg::WGT_W*i +: lnq_pkg::WGT_W];
         assign wgt_b = weights_b[lnq_pkg::WGT_W*i +: lnq_pkg::WGT_W];
      end else begin : g_idle
         assign act   = '0;
         assign wgt_a = '0;
         assign wgt_b = '0;
      end

      lnq_lane u_lane (
         .clock     (clock),
         .en        (req_fire),
         .act       (act),
         .wgt_a     (wgt_a),
         .wgt_b     (wgt_b),
         .prod_a_ff (prod_a[i]),
         .prod_b_ff (prod_b[i])
      );
   end

   // merge stage: accumulate, hand the finished sums to the requantizer
   logic [lnq_pkg::SUM_W-1:0] total_a, total_b;

   lnq_merge #(.LANES(LANES)) u_merge (
      .clock   (clock),
      .reset   (reset),
      .fire    (merge_fire),
      .last    (p_last_ff),
      .prod_a  (prod_a),
      .prod_b  (prod_b),
      .total_a (total_a),
      .total_b (total_b)
   );

   logic [lnq_pkg::SUM_W-1:0] q_sum_a_ff, q_sum_b_ff;
   logic [lnq_pkg::SUM_W-1:0] q_scale_a_ff, q_offset_a_ff, q_scale_b_ff, q_offset_b_ff;

   always_ff @(posedge clock) begin
      if (q_load) begin
         q_sum_a_ff    <= total_a;
         q_sum_b_ff    <= total_b;
         q_scale_a_ff  <= p_scale_a_ff;
         q_offset_a_ff <= p_offset_a_ff;
         q_scale_b_ff  <= p_scale_b_ff;
         q_offset_b_ff <= p_offset_b_ff;
      end
   end

   // requantizer: multiply registered inside, shift and clip feed the result register
   lnq_pkg::qctl_type         qctl;
   logic [lnq_pkg::NIB_W-1:0] nib_a, nib_b;

   assign qctl.load  = q_valid_ff && m_take;
   assign qctl.mode  = qmode;
   assign qctl.shift = shift_ff;

   lnq_quant u_quant_a (
      .clock  (clock),
      .ctl    (qctl),
      .sum    (q_sum_a_ff),
      .scale  (q_scale_a_ff),
      .offset (q_offset_a_ff),
      .mult   (mult_ff),
      .nibble (nib_a)
   );

   lnq_quant u_quant_b (
      .clock  (clock),
      .ctl    (qctl),
      .sum    (q_sum_b_ff),
      .scale  (q_scale_b_ff),
      .offset (q_offset_b_ff),
      .mult   (mult_ff),
      .nibble (nib_b)
   );

   // result register: hold while the receiver stalls
   logic [lnq_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign rsp_tdata_in = {nib_b, nib_a};

   always_ff @(posedge clock) begin
      if (m_valid_ff && out_take)
         rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // input stalls only when every requantizer stage is full
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_valid_ff && m_valid_ff && rsp_tvalid_ff)
      else $error("input stalled with room in the requantizer");

   a_mult_holds: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && !out_take |=> m_valid_ff)
      else $error("multiply stage dropped a result");

   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff && !m_take |=> q_valid_ff && $stable(q_sum_a_ff) && $stable(q_sum_b_ff))
      else $error("final sums changed while blocked");

   a_rsp_from_mult: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(m_valid_ff))
      else $error("result shown without a multiply stage entry");

endmodule
